FILE: hdl/pss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg: shared definitions for the positional sequence store
// Field widths, operation and status codes, default sizes and the control
// bundle that the top level drives into every storage cell.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Fixed widths of the stream fields
    localparam int OPCODE_W = 2;
    localparam int POS_W    = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    // Default sizes
    localparam int CAPACITY_DEF  = 256;
    localparam int WORD_BITS_DEF = 32;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Per-cell control: commit strobes and where the cell sits relative to
    // the target position
    typedef struct packed {
        logic ins;       // commit an insert this cycle
        logic del;       // commit a delete this cycle
        logic at_pos;    // cell index equals the target position
        logic above_pos; // cell index is greater than the target position
    } cell_ctl_t;

endpackage

FILE: hdl/pss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_cell: one storage cell of the sequence chain
// Holds one entry; takes the left neighbor on an insert above the target,
// the new value on an insert at it, the right neighbor on a delete at or
// above it, and drives its entry onto the read tree when at the target.
// ----------------------------------------------------------------------------
module pss_cell #(
    parameter int WORD_BITS = pss_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  pss_pkg::cell_ctl_t   ctl,
    input  logic [WORD_BITS-1:0] value_in,
    input  logic [WORD_BITS-1:0] left_in,
    input  logic [WORD_BITS-1:0] right_in,
    output logic [WORD_BITS-1:0] entry,
    output logic [WORD_BITS-1:0] sel
);
    import pss_pkg::*;

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins && ctl.above_pos)
        begin
            entry_next = left_in;
        end
        else if (ctl.ins && ctl.at_pos)
        begin
            entry_next = value_in;
        end
        else if (ctl.del && (ctl.at_pos || ctl.above_pos))
        begin
            entry_next = right_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign sel   = ctl.at_pos ? entry_reg : '0;

endmodule

FILE: hdl/pss_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_or_tree: registered 4-way OR reduction of the cell read outputs
// Only the cell at the target drives a nonzero word, so the root register
// holds that entry once it has passed through every level of node registers.
// ----------------------------------------------------------------------------
module pss_or_tree #(
    parameter int WORD_BITS = pss_pkg::WORD_BITS_DEF,
    parameter int CAPACITY  = pss_pkg::CAPACITY_DEF,
    parameter int LEVELS    = 4
) (
    input  logic                 clk,
    input  logic [WORD_BITS-1:0] leaf [CAPACITY],
    output logic [WORD_BITS-1:0] root
);
    import pss_pkg::*;

    localparam int LEAF_N = 1 << (2 * LEVELS);
    localparam int INNER_N = (LEAF_N - 1) / 3;

    logic [WORD_BITS-1:0] node_reg [INNER_N];
    logic [WORD_BITS-1:0] all_val  [INNER_N + LEAF_N];

    genvar g;
    generate
        for (g = 0; g < INNER_N; g++)
        begin : g_inner_val
            assign all_val[g] = node_reg[g];
        end
        for (g = 0; g < LEAF_N; g++)
        begin : g_leaf_val
            if (g < CAPACITY)
            begin : g_used
                assign all_val[INNER_N + g] = leaf[g];
            end
            else
            begin : g_pad
                assign all_val[INNER_N + g] = '0;
            end
        end
        for (g = 0; g < INNER_N; g++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                node_reg[g] <= all_val[4*g+1] | all_val[4*g+2]
                             | all_val[4*g+3] | all_val[4*g+4];
            end
        end
    endgenerate

    assign root = node_reg[0];

endmodule

FILE: hdl/positional_sequence_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_sequence_store: ordered word list with insert/delete at position
// A chain of CAPACITY cells holds the sequence; inserts and deletes shift
// every later entry together, reads go through a registered OR tree.
// ----------------------------------------------------------------------------
// The block keeps an ordered sequence of up to CAPACITY words and a count.
// Each request on the slave stream is one operation (tuser: insert, delete or
// read at a 0-based position) and yields exactly one result on the master
// stream with a status, the entry read (for read and delete) and the count
// after the operation. Insert at a position past the count or into a full
// store, and delete or read at a position not below the count, is flagged and
// leaves the store untouched; the unused opcode returns ok and changes
// nothing. Requests are taken one at a time: an insert, an error or the
// unused opcode does not wait on the read tree, while a read or delete
// waits until the registered read tree, LEVELS = ceil(log4(CAPACITY)) deep,
// holds the addressed cell; an operation finishes only once the output
// register is free. A result held in the output register does not stop
// the next request from being accepted. Entries need no clearing after
// reset; only positions below the count are ever read.
// Values are kept to their low WORD_BITS bits.
// ----------------------------------------------------------------------------
module positional_sequence_store #(
    parameter int CAPACITY  = pss_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = pss_pkg::WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Slave side: one operation per request
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, low bit up: position[8:0], value[40:9], zero pad [47:41]
    input  logic [pss_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [pss_pkg::OPCODE_W-1:0]   s_tuser,
    // Master side: one result per operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, low bit up: read_value[31:0], count_after[40:32], zero pad [47:41]
    output logic [pss_pkg::M_DATA_W-1:0]   m_tdata,
    // m_tuser: status[1:0]
    output logic [pss_pkg::STATUS_W-1:0]   m_tuser
);
    import pss_pkg::*;

    // Derived sizes
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEVELS  = ($clog2(CAPACITY) + 1) / 2;
    localparam int WAIT_W  = $clog2(LEVELS + 1);
    localparam int PAD_W   = M_DATA_W - VALUE_W - COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                 state_reg, state_next;
    logic [OPCODE_W-1:0]    op_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [WORD_BITS-1:0]   value_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [WAIT_W-1:0]      wait_reg, wait_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]     rdval_reg, rdval_next;
    logic [COUNT_W-1:0]     cnt_out_reg, cnt_out_next;

    logic                   s_accept;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic                   ins_range;
    logic                   ins_full;
    logic                   rd_range;
    logic                   need_tree;
    logic                   can_finish;
    logic                   out_free;
    logic                   finish;
    logic                   commit_ins;
    logic                   commit_del;

    logic [WORD_BITS-1:0]   entry_q [CAPACITY];
    logic [WORD_BITS-1:0]   sel_q   [CAPACITY];
    logic [WORD_BITS-1:0]   root;

    // Request handshake: take a request only between operations
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Range checks against the current count
    assign pos_ext   = CMP_W'(pos_reg);
    assign cnt_ext   = CMP_W'(count_reg);
    assign ins_range = pos_ext > cnt_ext;
    assign ins_full  = (count_reg == CNT_W'(CAPACITY));
    assign rd_range  = pos_ext >= cnt_ext;

    // Read and delete wait for the tree root to carry the addressed entry
    assign need_tree  = ((op_reg == OP_DELETE) || (op_reg == OP_READ)) && !rd_range;
    assign can_finish = !need_tree || (wait_reg == '0);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign finish     = (state_reg == S_EXEC) && can_finish && out_free;

    // Shift strobes fire once, together with the result write
    assign commit_ins = finish && (op_reg == OP_INSERT) && !ins_range && !ins_full;
    assign commit_del = finish && (op_reg == OP_DELETE) && !rd_range;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        wait_next     = wait_reg;
        m_tvalid_next = m_tvalid_reg;
        status_next   = status_reg;
        rdval_next    = rdval_reg;
        cnt_out_next  = cnt_out_reg;

        // Drop the held result once the consumer takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_EXEC;
                    wait_next  = WAIT_W'(LEVELS);
                end
            end
            S_EXEC:
            begin
                // Advance the tree wait while the leaves hold steady
                if (wait_reg != '0)
                begin
                    wait_next = wait_reg - WAIT_W'(1);
                end
                if (finish)
                begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                    status_next   = ST_OK;
                    rdval_next    = '0;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (ins_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (ins_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (rd_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rdval_next = VALUE_W'(root);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_READ:
                        begin
                            if (rd_range)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                rdval_next = VALUE_W'(root);
                            end
                        end
                        default:
                        begin
                            // unused opcode: ok, nothing changes
                        end
                    endcase
                    cnt_out_next = COUNT_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs; reset clears control only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            wait_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            wait_reg     <= wait_next;
            m_tvalid_reg <= m_tvalid_next;
            status_reg   <= status_next;
            rdval_reg    <= rdval_next;
            cnt_out_reg  <= cnt_out_next;
            if (s_accept)
            begin
                op_reg    <= s_tuser;
                pos_reg   <= s_tdata[POS_W-1:0];
                value_reg <= WORD_BITS'(s_tdata[POS_W+VALUE_W-1:POS_W]);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, cnt_out_reg, rdval_reg};

    // Cell chain: each cell sees its neighbors and its place relative to
    // the target position
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_ctl_t            ctl;
            logic [WORD_BITS-1:0] left_w;
            logic [WORD_BITS-1:0] right_w;

            assign ctl.ins       = commit_ins;
            assign ctl.del       = commit_del;
            assign ctl.at_pos    = (pos_ext == CMP_W'(i));
            assign ctl.above_pos = (pos_ext < CMP_W'(i));

            if (i == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = entry_q[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = entry_q[i+1];
            end

            pss_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .value_in (value_reg),
                .left_in  (left_w),
                .right_in (right_w),
                .entry    (entry_q[i]),
                .sel      (sel_q[i])
            );
        end
    endgenerate

    // Read path: collect the addressed cell over LEVELS registered stages
    pss_or_tree #(
        .WORD_BITS (WORD_BITS),
        .CAPACITY  (CAPACITY),
        .LEVELS    (LEVELS)
    ) u_tree (
        .clk  (clk),
        .leaf (sel_q),
        .root (root)
    );

endmodule
